@@ sv/tilt_pkg.sv @@
package tilt_pkg;

  // Sample and angle formats
  localparam int SAMPLE_WIDTH    = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_W         = 16;

  // Square root: radicand is (b^2 + c^2) << (2 * GUARD)
  localparam int GUARD  = 32 - SAMPLE_WIDTH;
  localparam int MAG_W  = SAMPLE_WIDTH + 1;
  localparam int SUM_W  = 2 * SAMPLE_WIDTH;
  localparam int ROOT_W = SAMPLE_WIDTH + GUARD;
  localparam int REM_W  = ROOT_W + 4;

  // CORDIC vectoring
  localparam int XY_W         = ROOT_W + 3;
  localparam int Z_FRAC       = 20;
  localparam int Z_W          = 29;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);

  // atan(2^-i) in degrees, scaled by 2^Z_FRAC
  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x_accel;
    logic signed [SAMPLE_WIDTH-1:0] y_accel;
    logic signed [SAMPLE_WIDTH-1:0] z_accel;
  } sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
  } angle_t;

  typedef struct packed {
    logic neg;
    logic zero_axis;
    logic zero_mag;
  } lane_flags_t;

  typedef struct packed {
    lane_flags_t        flags;
    logic [MAG_W-1:0]   mag;
    logic [SUM_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } sqrt_lane_t;

  typedef struct packed {
    logic             valid;
    sqrt_lane_t [1:0] lane;
  } sqrt_stage_t;

  typedef struct packed {
    lane_flags_t             flags;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_lane_t;

  typedef struct packed {
    logic               valid;
    cordic_lane_t [1:0] lane;
  } cordic_stage_t;

  function automatic logic signed [Z_W-1:0] atan_tab(input logic [STEP_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    v = '0;
    if (int'(idx) < CORDIC_STEPS) begin
      v = Z_W'(ATAN_TAB[idx]);
    end
    return v;
  endfunction

endpackage

@@ sv/tilt_sqrt_cell.sv @@
module tilt_sqrt_cell import tilt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  sqrt_stage_t prev,
  output sqrt_stage_t cur
);

  // One root bit per cell: shift in two radicand bits, try subtracting 4r+1.
  function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t l);
    sqrt_lane_t        n;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    n      = l;
    rem_sh = {l.rem[REM_W-3:0], l.rad[SUM_W-1:SUM_W-2]};
    trial  = REM_W'({l.root, 2'b01});
    n.rad  = {l.rad[SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      n.rem  = rem_sh - trial;
      n.root = {l.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = rem_sh;
      n.root = {l.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  logic             cur_valid;
  sqrt_lane_t [1:0] cur_lane;
  sqrt_lane_t [1:0] cur_lane_next;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cur_lane_next[l] = sqrt_step(prev.lane[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (en) begin
      cur_valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur_lane <= cur_lane_next;
    end
  end

  assign cur.valid = cur_valid;
  assign cur.lane  = cur_lane;

endmodule

@@ sv/tilt_cordic_cell.sv @@
module tilt_cordic_cell import tilt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [STEP_IDX_W-1:0] step,
  input  cordic_stage_t         prev,
  output cordic_stage_t         cur
);

  // Rotate toward y = 0 and accumulate the angle.
  function automatic cordic_lane_t cordic_step(input cordic_lane_t l,
                                               input logic [STEP_IDX_W-1:0] i);
    cordic_lane_t           n;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  t;
    n  = l;
    xs = l.x >>> i;
    ys = l.y >>> i;
    t  = atan_tab(i);
    if (!l.y[XY_W-1]) begin
      n.x = l.x + ys;
      n.y = l.y - xs;
      n.z = l.z + t;
    end else begin
      n.x = l.x - ys;
      n.y = l.y + xs;
      n.z = l.z - t;
    end
    return n;
  endfunction

  logic               cur_valid;
  cordic_lane_t [1:0] cur_lane;
  cordic_lane_t [1:0] cur_lane_next;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cur_lane_next[l] = cordic_step(prev.lane[l], step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (en) begin
      cur_valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur_lane <= cur_lane_next;
    end
  end

  assign cur.valid = cur_valid;
  assign cur.lane  = cur_lane;

endmodule

@@ sv/tilt_finish.sv @@
module tilt_finish import tilt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  cordic_stage_t prev,
  output logic          angle_valid,
  output angle_t        angle
);

  localparam logic signed [Z_W-1:0] Z_MAX      = Z_W'(90 * 2**Z_FRAC);
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(2**(Z_FRAC - 1 - ANGLE_FRAC_BITS));
  localparam logic signed [Z_W-1:0] FULL       = Z_W'(90 * 2**ANGLE_FRAC_BITS);

  // Clamp, round half up, apply sign and the degenerate cases.
  function automatic logic [ANGLE_W-1:0] finish_lane(input cordic_lane_t l);
    logic signed [Z_W-1:0] zc;
    logic signed [Z_W-1:0] r;
    zc = l.z;
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > Z_MAX) begin
      zc = Z_MAX;
    end
    r = (zc + ROUND_HALF) >>> (Z_FRAC - ANGLE_FRAC_BITS);
    if (r > FULL) begin
      r = FULL;
    end
    if (l.flags.zero_mag) begin
      r = FULL;
    end
    if (l.flags.neg) begin
      r = -r;
    end
    if (l.flags.zero_axis) begin
      r = '0;
    end
    return r[ANGLE_W-1:0];
  endfunction

  angle_t angle_next;

  always_comb begin
    angle_next.pitch_angle = finish_lane(prev.lane[0]);
    angle_next.roll_angle  = finish_lane(prev.lane[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (en) begin
      angle_valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule

@@ sv/accel_tilt_pitch_roll.sv @@
// Pitch and roll from one three-axis acceleration sample, 1/256 degree units.
// The chain holds 3 front stages, 32 square root cells, 24 CORDIC cells and
// 1 output stage, ending in the result register.
// Throughput: one item per cycle; every stage is a register that advances
// together, and a stalled output freezes the whole chain.
// Reset clears only the valid bits of the chain; payload registers are not reset.
module accel_tilt_pitch_roll import tilt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    angle_valid,
  input  logic    angle_stall,
  output angle_t  angle
);

  // Global advance: hold every stage only while a finished result waits.
  logic en;
  assign en           = !(angle_valid && angle_stall);
  assign sample_stall = !en;

  // ---------------------------------------------------------------------
  // Stage 0: capture the sample.
  // ---------------------------------------------------------------------
  logic    s0_valid;
  sample_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= sample;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: one square per axis, magnitudes, sign and zero flags of x and y.
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] sq_x_s;
  logic signed [SUM_W-1:0] sq_y_s;
  logic signed [SUM_W-1:0] sq_z_s;
  logic signed [MAG_W-1:0] x_ext;
  logic signed [MAG_W-1:0] y_ext;
  logic signed [MAG_W-1:0] mag_x_s;
  logic signed [MAG_W-1:0] mag_y_s;

  assign sq_x_s  = s0.x_accel * s0.x_accel;
  assign sq_y_s  = s0.y_accel * s0.y_accel;
  assign sq_z_s  = s0.z_accel * s0.z_accel;
  assign x_ext   = MAG_W'(s0.x_accel);
  assign y_ext   = MAG_W'(s0.y_accel);
  assign mag_x_s = x_ext[MAG_W-1] ? -x_ext : x_ext;
  assign mag_y_s = y_ext[MAG_W-1] ? -y_ext : y_ext;

  logic             s1_valid;
  logic [SUM_W-1:0] s1_sq_x;
  logic [SUM_W-1:0] s1_sq_y;
  logic [SUM_W-1:0] s1_sq_z;
  logic [MAG_W-1:0] s1_mag_x;
  logic [MAG_W-1:0] s1_mag_y;
  logic             s1_neg_x;
  logic             s1_neg_y;
  logic             s1_zero_x;
  logic             s1_zero_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sq_x   <= $unsigned(sq_x_s);
      s1_sq_y   <= $unsigned(sq_y_s);
      s1_sq_z   <= $unsigned(sq_z_s);
      s1_mag_x  <= $unsigned(mag_x_s);
      s1_mag_y  <= $unsigned(mag_y_s);
      s1_neg_x  <= s0.x_accel[SAMPLE_WIDTH-1];
      s1_neg_y  <= s0.y_accel[SAMPLE_WIDTH-1];
      s1_zero_x <= (s0.x_accel == '0);
      s1_zero_y <= (s0.y_accel == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sums of squares; load the first square root cell.
  // Lane 0 is pitch (x against yz), lane 1 is roll (y against xz).
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0] sum_p;
  logic [SUM_W-1:0] sum_r;
  sqrt_lane_t [1:0] s2_lane_next;

  assign sum_p = s1_sq_y + s1_sq_z;
  assign sum_r = s1_sq_x + s1_sq_z;

  always_comb begin
    s2_lane_next[0].flags.neg       = s1_neg_x;
    s2_lane_next[0].flags.zero_axis = s1_zero_x;
    s2_lane_next[0].flags.zero_mag  = (sum_p == '0);
    s2_lane_next[0].mag             = s1_mag_x;
    s2_lane_next[0].rad             = sum_p;
    s2_lane_next[0].rem             = '0;
    s2_lane_next[0].root            = '0;
    s2_lane_next[1].flags.neg       = s1_neg_y;
    s2_lane_next[1].flags.zero_axis = s1_zero_y;
    s2_lane_next[1].flags.zero_mag  = (sum_r == '0);
    s2_lane_next[1].mag             = s1_mag_y;
    s2_lane_next[1].rad             = sum_r;
    s2_lane_next[1].rem             = '0;
    s2_lane_next[1].root            = '0;
  end

  logic             s2_valid;
  sqrt_lane_t [1:0] s2_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_lane <= s2_lane_next;
    end
  end

  // ---------------------------------------------------------------------
  // Square root chain: each cell resolves one root bit.
  // ---------------------------------------------------------------------
  sqrt_stage_t sq_chain [ROOT_W+1];

  assign sq_chain[0].valid = s2_valid;
  assign sq_chain[0].lane  = s2_lane;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    tilt_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (sq_chain[g]),
      .cur  (sq_chain[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // CORDIC chain: x starts at the root, y at the scaled axis magnitude.
  // ---------------------------------------------------------------------
  cordic_stage_t cd_chain [CORDIC_STEPS+1];

  always_comb begin
    cd_chain[0].valid = sq_chain[ROOT_W].valid;
    for (int l = 0; l < 2; l++) begin
      cd_chain[0].lane[l].flags = sq_chain[ROOT_W].lane[l].flags;
      cd_chain[0].lane[l].x     = $signed(XY_W'(sq_chain[ROOT_W].lane[l].root));
      cd_chain[0].lane[l].y     =
        $signed(XY_W'({sq_chain[ROOT_W].lane[l].mag, {GUARD{1'b0}}}));
      cd_chain[0].lane[l].z     = '0;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    tilt_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .step (STEP_IDX_W'(g)),
      .prev (cd_chain[g]),
      .cur  (cd_chain[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output register: clamp, round, sign.
  // ---------------------------------------------------------------------
  tilt_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .prev        (cd_chain[CORDIC_STEPS]),
    .angle_valid (angle_valid),
    .angle       (angle)
  );

endmodule
